// ===== rtl/fct_pkg.sv =====
// ----------------------------------------------------------------------------
// fct_pkg
// Shared types and constants for the FAT cluster table engine.
// ----------------------------------------------------------------------------
package fct_pkg;

  localparam int TABLE_ENTRIES = 4096;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int PTR_W         = IDX_W + 1;
  // wide enough for a masked entry and for the table depth plus margin
  localparam int CMP_W         = (IDX_W + 2 > 29) ? IDX_W + 2 : 29;

  localparam int CLUSTER_W  = 12;
  localparam int VALUE_W    = 32;
  localparam int ENTRY_W    = 28;
  localparam int COUNT_W    = 12;
  localparam int CFG_DATA_W = 28;

  localparam logic [COUNT_W-1:0] CLUSTER_COUNT_RESET = 12'd4094;
  localparam logic [ENTRY_W-1:0] EOC_MIN_RESET       = 28'hFFFFFF8;

  typedef enum logic [1:0] {
    FUNC_READ       = 2'd0,
    FUNC_WRITE      = 2'd1,
    FUNC_FIND_FREE  = 2'd2,
    FUNC_FREE_CHAIN = 2'd3
  } fct_func_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NO_FREE   = 2'd1,
    STATUS_START_LOW = 2'd2,
    STATUS_BROKEN    = 2'd3
  } fct_status_t;

  typedef enum logic {
    CFG_CLUSTER_COUNT = 1'b0,
    CFG_EOC_MIN       = 1'b1
  } fct_cfg_idx_t;

  typedef struct packed {
    fct_func_t              func;
    logic [CLUSTER_W-1:0]   cluster;
    logic [VALUE_W-1:0]     entry_value;
  } fct_cmd_t;

  typedef struct packed {
    logic [ENTRY_W-1:0]     result_value;
    logic [COUNT_W-1:0]     freed_count;
    fct_status_t            status;
  } fct_result_t;

endpackage

// ===== rtl/fat_cluster_table_engine_core.sv =====
// ----------------------------------------------------------------------------
// fat_cluster_table_engine_core
// FAT allocation table engine: read, write, find-free and free-chain over a
// single table RAM driven by a small sequencer.
// ----------------------------------------------------------------------------
// Read passes S_READ and S_READ_DATA, write uses S_WRITE; find free scans from
// entry 2 below min(cluster_count + 2, table depth); free chain walks one entry per cycle.
// One item at a time; busy stays high until the done strobe goes out, and
// the table RAM read/write ports set the one-entry-per-cycle walk rate.
// Reset is synchronous; afterwards a clearing pass zeroes the table, one
// entry per cycle, with busy high. Results cannot stall.
module fat_cluster_table_engine_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  fct_pkg::fct_cmd_t                   cmd,
  output logic                                done,
  output fct_pkg::fct_result_t                result,
  input  logic                                cfg_we,
  input  fct_pkg::fct_cfg_idx_t               cfg_index,
  input  logic [fct_pkg::CFG_DATA_W-1:0]      cfg_data
);

  import fct_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_READ_DATA,
    S_WRITE,
    S_FIND,
    S_CHAIN_START,
    S_CHAIN
  } state_t;

  state_t               state;
  logic [CLUSTER_W-1:0] op_cluster;
  logic [ENTRY_W-1:0]   op_value;
  logic [IDX_W-1:0]     cur;
  logic [PTR_W-1:0]     ptr;
  logic                 chk_valid;
  logic [IDX_W-1:0]     chk_ptr;
  logic                 fwd_zero;
  logic [COUNT_W-1:0]   freed;
  logic [COUNT_W-1:0]   cluster_count;
  logic [ENTRY_W-1:0]   eoc_min;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [ENTRY_W-1:0]   ram_wdata;
  logic [IDX_W-1:0]     ram_raddr;
  logic [ENTRY_W-1:0]   ram_rdata;

  logic [CMP_W-1:0]     lim;
  logic [ENTRY_W-1:0]   next_val;
  logic                 next_valid;
  logic                 start_valid;
  logic                 in_range;
  logic [COUNT_W:0]     freed_inc;
  logic                 chain_end;
  logic                 chain_bad;
  logic                 find_hit;
  logic                 ptr_live;

  function automatic fct_result_t pack_result(logic [ENTRY_W-1:0] value,
                                              logic [COUNT_W-1:0] count,
                                              fct_status_t        st);
    fct_result_t r;
    r.result_value = value;
    r.freed_count  = count;
    r.status       = st;
    return r;
  endfunction

  fct_ram #(
    .DEPTH (TABLE_ENTRIES),
    .WIDTH (ENTRY_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign busy = (state != S_IDLE);

  // shared compare unit
  always_comb begin
    if (CMP_W'(cluster_count) + CMP_W'(2) < CMP_W'(TABLE_ENTRIES)) begin
      lim = CMP_W'(cluster_count) + CMP_W'(2);
    end else begin
      lim = CMP_W'(TABLE_ENTRIES);
    end
    // the entry just zeroed reads back as zero on a self link
    next_val    = fwd_zero ? '0 : ram_rdata;
    next_valid  = (CMP_W'(next_val) >= CMP_W'(2)) && (CMP_W'(next_val) < lim);
    start_valid = (CMP_W'(op_cluster) >= CMP_W'(2)) && (CMP_W'(op_cluster) < lim);
    in_range    = CMP_W'(op_cluster) < CMP_W'(TABLE_ENTRIES);
    freed_inc   = {1'b0, freed} + 1'b1;
    chain_end   = next_val >= eoc_min;
    chain_bad   = (freed_inc >= {1'b0, cluster_count}) || !next_valid;
    find_hit    = chk_valid && (ram_rdata == '0);
    ptr_live    = CMP_W'(ptr) < lim;
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur;
    ram_wdata = '0;
    ram_raddr = cur;
    unique case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
      end
      S_READ, S_CHAIN_START: begin
        ram_raddr = IDX_W'(op_cluster);
      end
      S_WRITE: begin
        ram_we    = in_range;
        ram_waddr = IDX_W'(op_cluster);
        ram_wdata = op_value;
      end
      S_FIND: begin
        ram_raddr = ptr[IDX_W-1:0];
      end
      S_CHAIN: begin
        ram_we    = 1'b1;
        ram_raddr = IDX_W'(next_val);
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      cur           <= '0;
      chk_valid     <= 1'b0;
      done          <= 1'b0;
      cluster_count <= CLUSTER_COUNT_RESET;
      eoc_min       <= EOC_MIN_RESET;
    end else begin
      done <= 1'b0;

      if (cfg_we) begin
        unique case (cfg_index)
          CFG_CLUSTER_COUNT: cluster_count <= cfg_data[COUNT_W-1:0];
          CFG_EOC_MIN:       eoc_min       <= cfg_data[ENTRY_W-1:0];
        endcase
      end

      unique case (state)
        S_CLEAR: begin
          cur <= cur + 1'b1;
          if (cur == IDX_W'(TABLE_ENTRIES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            op_cluster <= cmd.cluster;
            op_value   <= cmd.entry_value[ENTRY_W-1:0];
            unique case (cmd.func)
              FUNC_READ:  state <= S_READ;
              FUNC_WRITE: state <= S_WRITE;
              FUNC_FIND_FREE: begin
                ptr       <= PTR_W'(2);
                chk_valid <= 1'b0;
                state     <= S_FIND;
              end
              FUNC_FREE_CHAIN: state <= S_CHAIN_START;
            endcase
          end
        end
        S_READ: begin
          state <= S_READ_DATA;
        end
        S_READ_DATA: begin
          result <= pack_result(in_range ? ram_rdata : '0, '0, STATUS_OK);
          done   <= 1'b1;
          state  <= S_IDLE;
        end
        S_WRITE: begin
          result <= pack_result('0, '0, STATUS_OK);
          done   <= 1'b1;
          state  <= S_IDLE;
        end
        S_FIND: begin
          // check the entry read last cycle while issuing the next one
          if (find_hit) begin
            result <= pack_result(ENTRY_W'(chk_ptr), '0, STATUS_OK);
            done   <= 1'b1;
            state  <= S_IDLE;
          end else if (ptr_live) begin
            chk_valid <= 1'b1;
            chk_ptr   <= ptr[IDX_W-1:0];
            ptr       <= ptr + 1'b1;
          end else begin
            result <= pack_result('0, '0, STATUS_NO_FREE);
            done   <= 1'b1;
            state  <= S_IDLE;
          end
        end
        S_CHAIN_START: begin
          if (CMP_W'(op_cluster) < CMP_W'(2)) begin
            result <= pack_result('0, '0, STATUS_START_LOW);
            done   <= 1'b1;
            state  <= S_IDLE;
          end else if (!start_valid) begin
            result <= pack_result('0, '0, STATUS_BROKEN);
            done   <= 1'b1;
            state  <= S_IDLE;
          end else begin
            cur      <= IDX_W'(op_cluster);
            fwd_zero <= 1'b0;
            freed    <= '0;
            state    <= S_CHAIN;
          end
        end
        S_CHAIN: begin
          freed <= freed_inc[COUNT_W-1:0];
          if (chain_end) begin
            result <= pack_result('0, freed_inc[COUNT_W-1:0], STATUS_OK);
            done   <= 1'b1;
            state  <= S_IDLE;
          end else if (chain_bad) begin
            result <= pack_result('0, freed_inc[COUNT_W-1:0], STATUS_BROKEN);
            done   <= 1'b1;
            state  <= S_IDLE;
          end else begin
            cur      <= IDX_W'(next_val);
            fwd_zero <= (IDX_W'(next_val) == cur);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("done strobe without a preceding operation");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !ram_we)
    else $error("table written while idle");

  a_no_free_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == STATUS_NO_FREE) |-> (result.result_value == '0))
    else $error("no-free result carries a cluster index");

  a_start_low_nothing: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == STATUS_START_LOW) |-> (result.freed_count == '0))
    else $error("ignored chain start reports freed entries");

endmodule

// ===== rtl/fct_ram.sv =====
// ----------------------------------------------------------------------------
// fct_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fct_ram #(
  parameter int  DEPTH = 4096,
  parameter int  WIDTH = 28,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
